FILE: hw/rtl/mafm_pkg.sv
// mafm_pkg: shared constants, tables, functions and struct types of the angular fan mask block
// no dependencies; imported by every module of the block
package mafm_pkg;

	localparam int MAX_DIMENSION       = 4096;
	localparam int ANGLE_FRACTION_BITS = 16;
	localparam int CORDIC_PREC         = 28;
	localparam int N_ITER              = ANGLE_FRACTION_BITS + 2;
	localparam int CW                  = 46;
	localparam int ZW                  = ANGLE_FRACTION_BITS + 4;
	localparam int ZCW                 = ANGLE_FRACTION_BITS + 1;
	localparam int DROP                = 30 - ANGLE_FRACTION_BITS;
	localparam longint ANGLE_LIMIT     =
		(64'd999 * (64'd1 << ANGLE_FRACTION_BITS) + 64'd500) / 64'd1000;
	localparam int SOFT_SCALE          = 224;
	localparam int FULL_SCALE          = 256;
	localparam int SOFT_OFFSET         = 16;
	localparam int QDEPTH              = 16;
	localparam int QAW                 = $clog2(QDEPTH);
	localparam int QCW                 = QAW + 1;

	localparam logic [31:0] ATAN_TAB [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
	};

	typedef enum logic [2:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_SOFT   = 3'd2,
		REG_DUAL   = 3'd3,
		REG_BOTTOM = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [10:0] quad_col;
		logic [11:0] quad_row;
	} item_t;

	typedef struct packed {
		logic [11:0] pixel_row;
		logic [11:0] pixel_col;
		logic [7:0]  pixel_value;
		logic        last_write;
	} result_t;

	typedef struct packed {
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic        soft_mode;
		logic        dual_fan;
		logic        from_bottom;
	} cfg_t;

	typedef struct packed {
		logic [11:0] row_a;
		logic [11:0] row_b;
		logic [11:0] col_a;
		logic [11:0] col_b;
		logic        dual;
	} pix_t;

	typedef struct packed {
		logic        valid;
		logic [10:0] xf;
		logic [11:0] yf;
		logic        soft_en;
		pix_t        pix;
	} job_t;

	typedef struct packed {
		pix_t       pix;
		logic [7:0] value;
	} entry_t;

	function automatic logic [ZW-1:0] atan_step(input int i);
		logic [32:0] t;
		begin
			t = 33'(ATAN_TAB[i]) + (33'd1 << (DROP - 1));
			return ZW'(t >> DROP);
		end
	endfunction

	function automatic logic [12:0] sat_dim(input logic [12:0] r);
		begin
			return (r > 13'(MAX_DIMENSION)) ? 13'(MAX_DIMENSION) : r;
		end
	endfunction

endpackage

FILE: hw/rtl/mafm_front.sv
// mafm_front: accepts coordinates, checks the active region, forms mirrored pixel addresses
// depends on mafm_pkg; tracks queue credits and drives busy
module mafm_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  mafm_pkg::item_t item,
	input  mafm_pkg::cfg_t  cfg,
	input  logic            pop,
	output logic            busy,
	output mafm_pkg::job_t  job
);
	import mafm_pkg::*;

	logic [QCW-1:0] credits_q;
	logic           accept;
	logic           active;
	logic [12:0]    w;
	logic [12:0]    h;
	logic [12:0]    w1;
	logic [12:0]    h1;
	logic [12:0]    col13;
	logic [12:0]    row13;
	logic [11:0]    cm;
	logic [11:0]    rm;
	logic           vld_s1;
	job_t           job_s1;

	assign w     = sat_dim(cfg.image_width);
	assign h     = sat_dim(cfg.image_height);
	assign w1    = 13'((14'(w) + 14'd1) >> 1);
	assign h1    = cfg.dual_fan ? 13'((14'(h) + 14'd1) >> 1) : h;
	assign col13 = 13'(item.quad_col);
	assign row13 = 13'(item.quad_row);
	assign active = (col13 < w1) && (row13 < h1);
	assign cm    = 12'(w - col13 - 13'd1);
	assign rm    = 12'(h - row13 - 13'd1);

	assign busy   = (credits_q == QCW'(QDEPTH));
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credits_q <= '0;
			vld_s1    <= 1'b0;
		end else begin
			credits_q <= credits_q + QCW'(accept && active) - QCW'(pop);
			vld_s1    <= accept && active;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1.valid     <= active;
			job_s1.xf        <= 11'(w1 - col13 - 13'd1);
			job_s1.yf        <= item.quad_row;
			job_s1.soft_en   <= cfg.soft_mode;
			job_s1.pix.row_a <= (!cfg.dual_fan && cfg.from_bottom) ? rm : item.quad_row;
			job_s1.pix.row_b <= rm;
			job_s1.pix.col_a <= 12'(item.quad_col);
			job_s1.pix.col_b <= cm;
			job_s1.pix.dual  <= cfg.dual_fan;
		end
	end

	always_comb begin
		job       = job_s1;
		job.valid = vld_s1;
	end

endmodule

FILE: hw/rtl/mafm_cordic.sv
// mafm_cordic: pipelined vectoring cordic for the quarter-turn angle, clamp and byte scaling
// depends on mafm_pkg; one stage per iteration, one item per cycle, no stall
module mafm_cordic (
	input  logic             clk,
	input  logic             arst_n,
	input  mafm_pkg::job_t   job,
	output logic             push,
	output mafm_pkg::entry_t entry
);
	import mafm_pkg::*;

	localparam logic signed [ZW-1:0] LIM_Z = ZW'(ANGLE_LIMIT);

	logic                 vld_s [0:N_ITER];
	logic signed [CW-1:0] cx_s  [0:N_ITER];
	logic signed [CW-1:0] cy_s  [0:N_ITER];
	logic signed [ZW-1:0] cz_s  [0:N_ITER];
	logic                 soft_s[0:N_ITER];
	pix_t                 pix_s [0:N_ITER];

	logic [ZCW-1:0]       zc;
	logic [8:0]           mult;
	logic [ZCW+8:0]       prod;
	logic                 push_q;
	entry_t               entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= job.valid;
		end
	end

	always_ff @(posedge clk) begin
		cx_s[0]   <= CW'(job.yf) << CORDIC_PREC;
		cy_s[0]   <= CW'(job.xf) << CORDIC_PREC;
		cz_s[0]   <= '0;
		soft_s[0] <= job.soft_en;
		pix_s[0]  <= job.pix;
	end

	for (genvar i = 0; i < N_ITER; i++) begin : g_iter
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic signed [ZW-1:0] step;

		assign sx   = cx_s[i] >>> i;
		assign sy   = cy_s[i] >>> i;
		assign step = $signed(atan_step(i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			soft_s[i+1] <= soft_s[i];
			pix_s[i+1]  <= pix_s[i];
			if (cy_s[i] > 0) begin
				cx_s[i+1] <= cx_s[i] + sy;
				cy_s[i+1] <= cy_s[i] - sx;
				cz_s[i+1] <= cz_s[i] + step;
			end else if (cy_s[i] < 0) begin
				cx_s[i+1] <= cx_s[i] - sy;
				cy_s[i+1] <= cy_s[i] + sx;
				cz_s[i+1] <= cz_s[i] - step;
			end else begin
				cx_s[i+1] <= cx_s[i];
				cy_s[i+1] <= cy_s[i];
				cz_s[i+1] <= cz_s[i];
			end
		end
	end

	always_comb begin
		priority if (cz_s[N_ITER] < 0) begin
			zc = '0;
		end else if (cz_s[N_ITER] > LIM_Z) begin
			zc = ZCW'(LIM_Z);
		end else begin
			zc = ZCW'(cz_s[N_ITER]);
		end
		mult = soft_s[N_ITER] ? 9'(SOFT_SCALE) : 9'(FULL_SCALE);
		prod = (ZCW+9)'(zc) * (ZCW+9)'(mult);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_q <= 1'b0;
		end else begin
			push_q <= vld_s[N_ITER];
		end
	end

	always_ff @(posedge clk) begin
		entry_q.pix   <= pix_s[N_ITER];
		entry_q.value <= 8'(prod >> ANGLE_FRACTION_BITS)
			+ (soft_s[N_ITER] ? 8'(SOFT_OFFSET) : 8'd0);
	end

	assign push  = push_q;
	assign entry = entry_q;

endmodule

FILE: hw/rtl/mafm_queue.sv
// mafm_queue: short fifo of scaled items between the cordic pipeline and the writer
// depends on mafm_pkg; never overfilled thanks to the credit count in the front
module mafm_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mafm_pkg::entry_t wdata,
	input  logic             pop,
	output logic             empty,
	output mafm_pkg::entry_t head
);
	import mafm_pkg::*;

	entry_t         mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW-1:0] rd_next;
	logic [QCW-1:0] count_q;
	entry_t         head_q;

	assign empty   = (count_q == '0);
	assign rd_next = rd_ptr_q + QAW'(pop);
	assign head    = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCW'(push) - QCW'(pop);
		end
	end

	// head register follows the next read address, with bypass of a same-cycle write
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
		if (push && (wr_ptr_q == rd_next)) begin
			head_q <= wdata;
		end else begin
			head_q <= mem_q[rd_next];
		end
	end

endmodule

FILE: hw/rtl/mafm_back.sv
// mafm_back: writes each queued item to its two or four mirrored pixels, one per cycle
// depends on mafm_pkg; pops the queue and registers the result outputs
module mafm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  mafm_pkg::entry_t  head,
	output logic              pop,
	output logic              strobe,
	output mafm_pkg::result_t result
);
	import mafm_pkg::*;

	logic       cur_vld_q;
	entry_t     cur_q;
	logic [1:0] idx_q;
	logic       last;
	logic       strobe_q;
	result_t    result_q;

	assign last = cur_q.pix.dual ? (idx_q == 2'd3) : (idx_q == 2'd1);
	assign pop  = !empty && (!cur_vld_q || last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			idx_q     <= '0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= cur_vld_q;
			if (pop) begin
				cur_vld_q <= 1'b1;
				idx_q     <= '0;
			end else if (cur_vld_q && last) begin
				cur_vld_q <= 1'b0;
			end else if (cur_vld_q) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		result_q.pixel_row   <= idx_q[1] ? cur_q.pix.row_b : cur_q.pix.row_a;
		result_q.pixel_col   <= idx_q[0] ? cur_q.pix.col_b : cur_q.pix.col_a;
		result_q.pixel_value <= cur_q.value;
		result_q.last_write  <= last;
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

FILE: hw/rtl/mirrored_angular_fan_mask_top.sv
// mirrored_angular_fan_mask_top: configuration registers and the front, cordic, queue, back chain
// first result passes the front, cordic, queue and back registers; further writes one a cycle
// each item takes two writes in single fan mode and four in dual mode at the
// one-write-per-cycle result port; the front takes an item a cycle while queue credits remain
// reset: registers return to their defaults, pipeline and queue come up empty
// the receiver cannot stall; depends on mafm_pkg and the four mafm modules
module mirrored_angular_fan_mask_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mafm_pkg::item_t   item,
	output logic              busy,
	output logic              strobe,
	output mafm_pkg::result_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import mafm_pkg::*;

	cfg_t   cfg_q;
	logic   wr_en;
	logic   pop;
	logic   push;
	logic   empty;
	job_t   job;
	entry_t entry;
	entry_t head;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= 13'(MAX_DIMENSION);
			cfg_q.image_height <= 13'(MAX_DIMENSION);
			cfg_q.soft_mode    <= 1'b0;
			cfg_q.dual_fan     <= 1'b0;
			cfg_q.from_bottom  <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_WIDTH:  cfg_q.image_width  <= pwdata[12:0];
				REG_HEIGHT: cfg_q.image_height <= pwdata[12:0];
				REG_SOFT:   cfg_q.soft_mode    <= pwdata[0];
				REG_DUAL:   cfg_q.dual_fan     <= pwdata[0];
				REG_BOTTOM: cfg_q.from_bottom  <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_WIDTH:  prdata = 32'(cfg_q.image_width);
			REG_HEIGHT: prdata = 32'(cfg_q.image_height);
			REG_SOFT:   prdata = 32'(cfg_q.soft_mode);
			REG_DUAL:   prdata = 32'(cfg_q.dual_fan);
			REG_BOTTOM: prdata = 32'(cfg_q.from_bottom);
			default:    prdata = '0;
		endcase
	end

	mafm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.cfg    (cfg_q),
		.pop    (pop),
		.busy   (busy),
		.job    (job)
	);

	mafm_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (job),
		.push   (push),
		.entry  (entry)
	);

	mafm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (entry),
		.pop    (pop),
		.empty  (empty),
		.head   (head)
	);

	mafm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.strobe (strobe),
		.result (result)
	);

endmodule

FILE: bench/testbench.sv
// testbench: self-checking bench for mirrored_angular_fan_mask_top, driving pixel coordinates
// and APB register writes, predicting every mirrored pixel write and its mask byte
// depends on mafm_pkg and the RTL of mirrored_angular_fan_mask_top
module testbench;
	import mafm_pkg::*;

	localparam int TURN_DROP   = 30 - ANGLE_FRACTION_BITS;
	localparam int SETTLE      = 40;
	localparam int CYCLE_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	item_t       item = '0;
	logic        busy;
	logic        strobe;
	result_t     result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	item_t       coords_pending[$];
	result_t     writes_due[$];
	logic [12:0] cfg_regs[5];
	int          gap_pct = 34;
	int          failures = 0;
	int          coords_taken = 0;
	int          writes_checked = 0;
	int          settings_done = 0;
	int          cycle_count = 0;

	mirrored_angular_fan_mask_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.strobe(strobe),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("mirrored_angular_fan_mask_top test failed");
			$finish;
		end
	end

	// quarter-turn angle of (xf, yf) by vectoring cordic, scaled to a byte
	function automatic logic [7:0] fan_byte(input longint xf, input longint yf,
			input logic soft_en);
		longint x, y, z, sx, sy, step_q, cap;
		x = yf <<< CORDIC_PREC;
		y = xf <<< CORDIC_PREC;
		z = 0;
		cap = (999 * (longint'(1) <<< ANGLE_FRACTION_BITS) + 500) / 1000;
		for (int i = 0; i < ANGLE_FRACTION_BITS + 2 && i < 32; i++) begin
			step_q = longint'((64'(ATAN_TAB[i]) + (64'd1 << (TURN_DROP - 1))) >> TURN_DROP);
			sx = x >>> i;
			sy = y >>> i;
			if (y > 0) begin
				x = x + sy;
				y = y - sx;
				z = z + step_q;
			end else if (y < 0) begin
				x = x - sy;
				y = y + sx;
				z = z - step_q;
			end
		end
		if (z < 0)
			z = 0;
		if (z > cap)
			z = cap;
		if (soft_en)
			return 8'(((z * SOFT_SCALE) >>> ANGLE_FRACTION_BITS) + SOFT_OFFSET);
		return 8'((z * FULL_SCALE) >>> ANGLE_FRACTION_BITS);
	endfunction

	function automatic void frame_dims(output int unsigned w, output int unsigned h,
			output int unsigned w1, output int unsigned h1);
		w = (cfg_regs[REG_WIDTH] > MAX_DIMENSION) ? MAX_DIMENSION : cfg_regs[REG_WIDTH];
		h = (cfg_regs[REG_HEIGHT] > MAX_DIMENSION) ? MAX_DIMENSION : cfg_regs[REG_HEIGHT];
		w1 = (w + 1) / 2;
		h1 = cfg_regs[REG_DUAL][0] ? (h + 1) / 2 : h;
	endfunction

	function automatic void push_write(input int unsigned r, input int unsigned c,
			input logic [7:0] v, input logic last);
		result_t wr;
		wr.pixel_row = 12'(r);
		wr.pixel_col = 12'(c);
		wr.pixel_value = v;
		wr.last_write = last;
		writes_due.push_back(wr);
	endfunction

	function automatic void predict_writes(input item_t it);
		int unsigned w, h, w1, h1, col, row, cm, rm;
		logic [7:0] v;
		frame_dims(w, h, w1, h1);
		col = it.quad_col;
		row = it.quad_row;
		if (col >= w1 || row >= h1)
			return;
		v = fan_byte(w1 - col - 1, row, cfg_regs[REG_SOFT][0]);
		cm = w - col - 1;
		rm = h - row - 1;
		if (cfg_regs[REG_DUAL][0]) begin
			push_write(row, col, v, 1'b0);
			push_write(row, cm, v, 1'b0);
			push_write(rm, col, v, 1'b0);
			push_write(rm, cm, v, 1'b1);
		end else begin
			if (cfg_regs[REG_BOTTOM][0])
				row = rm;
			push_write(row, col, v, 1'b0);
			push_write(row, cm, v, 1'b1);
		end
	endfunction

	// driver: one coordinate per accept, random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_writes(item);
				coords_taken++;
			end
			if (!start || !busy) begin
				if (coords_pending.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
					item <= coords_pending.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every strobe is one pixel write
	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n && strobe === 1'b1) begin
			if (writes_due.size() == 0) begin
				$error("unexpected pixel write row %0d col %0d value %0d",
					result.pixel_row, result.pixel_col, result.pixel_value);
				failures++;
			end else begin
				want = writes_due.pop_front();
				writes_checked++;
				if (result.pixel_row !== want.pixel_row) begin
					$error("pixel_row: expected %0d, got %0d", want.pixel_row, result.pixel_row);
					failures++;
				end
				if (result.pixel_col !== want.pixel_col) begin
					$error("pixel_col: expected %0d, got %0d", want.pixel_col, result.pixel_col);
					failures++;
				end
				if (result.pixel_value !== want.pixel_value) begin
					$error("pixel_value: expected %0d, got %0d",
						want.pixel_value, result.pixel_value);
					failures++;
				end
				if (result.last_write !== want.last_write) begin
					$error("last_write: expected %0d, got %0d",
						want.last_write, result.last_write);
					failures++;
				end
			end
		end
	end

	task automatic apb_access(input logic wr, input logic [4:0] a, input logic [31:0] d,
			output logic [31:0] rd);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_reg(input reg_idx_t r, input logic [12:0] v);
		logic [31:0] rd;
		logic [12:0] got;
		if (r != REG_WIDTH && r != REG_HEIGHT)
			v = 13'(v[0]);
		apb_access(1'b1, 5'(4 * r), 32'(v), rd);
		cfg_regs[r] = v;
		apb_access(1'b0, 5'(4 * r), '0, rd);
		got = (r == REG_WIDTH || r == REG_HEIGHT) ? rd[12:0] : 13'(rd[0]);
		if (got !== v) begin
			$error("%s readback: expected %0d, got %0d", r.name(), v, got);
			failures++;
		end
	endtask

	task automatic set_all(input logic [12:0] w, input logic [12:0] h,
			input logic soft_en, input logic dual, input logic bottom);
		set_reg(REG_WIDTH, w);
		set_reg(REG_HEIGHT, h);
		set_reg(REG_SOFT, 13'(soft_en));
		set_reg(REG_DUAL, 13'(dual));
		set_reg(REG_BOTTOM, 13'(bottom));
		settings_done++;
	endtask

	task automatic queue_coord(input int unsigned col, input int unsigned row);
		item_t c;
		c.quad_col = 11'(col);
		c.quad_row = 12'(row);
		coords_pending.push_back(c);
	endtask

	// wait until every item is taken and written out, then let stragglers settle
	task automatic drain();
		while (coords_pending.size() != 0 || start)
			@(posedge clk);
		while (writes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic random_coords(input int n);
		int unsigned w, h, w1, h1, col, row, pick;
		frame_dims(w, h, w1, h1);
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 20 || w1 == 0 || h1 == 0) begin
				col = $urandom_range(0, 2047);
				row = $urandom_range(0, 4095);
			end else begin
				col = $urandom_range(0, w1 - 1);
				row = $urandom_range(0, h1 - 1);
				if (pick < 28)
					col = w1 - 1;
				else if (pick < 34)
					row = 0;
			end
			queue_coord(col, row);
		end
	endtask

	function automatic logic [12:0] random_dim();
		case ($urandom_range(0, 3))
			0: return 13'($urandom_range(1, 64));
			1: return 13'($urandom_range(1, 8191));
			2: return 13'(MAX_DIMENSION);
			default: return 13'($urandom_range(1, 4096));
		endcase
	endfunction

	initial begin : stimulus
		logic [31:0] rd;
		cfg_regs[REG_WIDTH] = 13'd4096;
		cfg_regs[REG_HEIGHT] = 13'd4096;
		cfg_regs[REG_SOFT] = '0;
		cfg_regs[REG_DUAL] = '0;
		cfg_regs[REG_BOTTOM] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset defaults: full frame, single fan from top, full scale
		queue_coord(0, 0);
		queue_coord(2047, 4095);
		queue_coord(0, 4095);
		queue_coord(2047, 0);
		queue_coord(1024, 2048);
		queue_coord(0, 1);
		drain();

		// oversized width saturates, soft dual fan
		set_all(13'd8191, 13'd4096, 1'b1, 1'b1, 1'b0);
		queue_coord(0, 0);
		queue_coord(0, 2047);
		queue_coord(0, 2048);
		queue_coord(2047, 4095);
		queue_coord(2047, 100);
		drain();

		// write to an unmapped register must leave the setting alone
		apb_access(1'b1, 5'd20, 32'hFFFF_FFFF, rd);
		queue_coord(5, 5);
		drain();

		// one pixel frame: all mirrored writes coincide
		set_all(13'd1, 13'd1, 1'b0, 1'b0, 1'b1);
		queue_coord(0, 0);
		queue_coord(1, 0);
		queue_coord(0, 1);
		drain();

		// zero size frame: nothing is active
		set_all(13'd0, 13'd0, 1'b0, 1'b0, 1'b0);
		queue_coord(0, 0);
		queue_coord(5, 5);
		drain();

		// odd sizes in dual mode: center row and column coincide
		set_all(13'd7, 13'd5, 1'b1, 1'b1, 1'b0);
		queue_coord(3, 2);
		queue_coord(0, 0);
		queue_coord(3, 3);
		drain();

		for (int p = 0; p < 6; p++) begin
			gap_pct = (p < 2) ? 34 : (p < 4) ? 61 : 0;
			if (p == 0)
				set_all(13'd4096, 13'd4096, 1'($urandom_range(0, 1)), 1'b0,
					1'($urandom_range(0, 1)));
			else
				set_all(random_dim(), random_dim(), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			random_coords(15);
			drain();
		end

		$display("coverage: %0d coordinates taken, %0d pixel writes checked",
			coords_taken, writes_checked);
		$display("coverage: %0d register settings incl. saturated, zero and odd sizes",
			settings_done);
		if (failures == 0)
			$display("mirrored_angular_fan_mask_top test passed");
		else
			$display("mirrored_angular_fan_mask_top test failed");
		$finish;
	end
endmodule
